@@ rtl/core/s2da_pkg.sv @@
`timescale 1ns / 1ps
package s2da_pkg;

  localparam int unsigned VALUE_BITS_DEFAULT = 32;
  localparam int unsigned DABBLE_STEPS       = 8;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // decimal digits for an unsigned magnitude of the given width
  function automatic int unsigned num_digits(input int unsigned bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

endpackage

@@ rtl/core/s2da_dabble_stage.sv @@
`timescale 1ns / 1ps
module s2da_dabble_stage
  import s2da_pkg::*;
#(
  parameter int unsigned MAG_BITS   = VALUE_BITS_DEFAULT,
  parameter int unsigned NUM_DIGITS = num_digits(VALUE_BITS_DEFAULT),
  parameter int unsigned STEPS      = DABBLE_STEPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_neg_i,
  input  logic [MAG_BITS-1:0]     in_bin_i,
  input  logic [4*NUM_DIGITS-1:0] in_bcd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_neg_o,
  output logic [MAG_BITS-1:0]     out_bin_o,
  output logic [4*NUM_DIGITS-1:0] out_bcd_o
);

  logic                    valid_q;
  logic                    neg_q;
  logic [MAG_BITS-1:0]     bin_q, bin_d;
  logic [4*NUM_DIGITS-1:0] bcd_q, bcd_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // shift-add-3: adjust every digit, then shift one binary bit in
  always_comb begin
    bcd_d = in_bcd_i;
    bin_d = in_bin_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_d[4*d +: 4] >= BCD_ADJ_MIN) begin
          bcd_d[4*d +: 4] = bcd_d[4*d +: 4] + BCD_ADJ_ADD;
        end
      end
      {bcd_d, bin_d} = {bcd_d, bin_d} << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      neg_q <= in_neg_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_bin_o   = bin_q;
  assign out_bcd_o   = bcd_q;

endmodule

@@ rtl/core/s2da_serializer.sv @@
`timescale 1ns / 1ps
module s2da_serializer
  import s2da_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = num_digits(VALUE_BITS_DEFAULT)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_neg_i,
  input  logic [4*NUM_DIGITS-1:0] in_bcd_i,
  output logic                    char_valid_o,
  output logic [7:0]              char_code_o,
  output logic                    last_o
);

  localparam int unsigned CNT_BITS = $clog2(NUM_DIGITS + 1);
  localparam int unsigned IDX_BITS = $clog2(NUM_DIGITS);

  logic                    busy_q;
  logic                    neg_q;
  logic [4*NUM_DIGITS-1:0] digits_q;
  logic [CNT_BITS-1:0]     left_q;
  logic [CNT_BITS-1:0]     nd_d;
  logic [IDX_BITS-1:0]     idx;
  logic [3:0]              digit;
  logic                    load;

  // count significant digits, at least one
  always_comb begin
    nd_d = CNT_BITS'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (in_bcd_i[4*d +: 4] != 4'd0) begin
        nd_d = CNT_BITS'(d + 1);
      end
    end
  end

  assign idx   = IDX_BITS'(left_q - 1'b1);
  assign digit = digits_q[{idx, 2'b00} +: 4];

  assign char_valid_o = busy_q;
  assign char_code_o  = neg_q ? ASCII_MINUS : ASCII_ZERO + {4'd0, digit};
  assign last_o       = !neg_q && (left_q == CNT_BITS'(1));
  assign in_ready_o   = !busy_q || last_o;
  assign load         = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      left_q <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      neg_q  <= in_neg_i;
      left_q <= nd_d;
    end else if (busy_q) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        left_q <= left_q - 1'b1;
        if (last_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= in_bcd_i;
    end
  end

`ifndef ASSERT_OFF
  a_word_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !last_o |=> char_valid_o)
    else $error("character stream broken before last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (left_q != '0) && (left_q <= CNT_BITS'(NUM_DIGITS)))
    else $error("digit count out of range");

  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (char_code_o == ASCII_MINUS) ||
                     ((char_code_o >= ASCII_ZERO) &&
                      (char_code_o <= ASCII_ZERO + {4'd0, BCD_DIGIT_MAX})))
    else $error("character code not a sign or digit");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(char_valid_o) && !$past(last_o) && char_valid_o |->
      char_code_o != ASCII_MINUS)
    else $error("minus sign after first character");
`endif

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text.
// Input: drive value_i and raise start; the word is taken at a rising edge
// where start is high and busy is low. Only VALUE_BITS bits are used, taken
// as two's complement.
// Output: one character per cycle on char_code_o, marked by char_valid_o,
// most significant first: '-' for a negative value, then the digits without
// leading zeros (zero gives a single '0'). last_o flags the final character.
// The most negative value prints in full.
// The accepting edge loads the sign and magnitude into the front register;
// the word then passes through the registered shift-add-3 stages, each of up
// to eight bits, and into the character serialiser, which shows the first
// character as soon as it has loaded the word.
// The serialiser emits one character per cycle; a number has 1 to 11
// characters at 32 bits, and the stages in front hold further words
// meanwhile; busy rises when they are full.
// The receiver cannot stall: each character is valid for exactly one cycle.
// Reset clears all valid bits; nothing is emitted until a word is taken.
module signed_int_to_decimal_ascii_unit
  import s2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  char_valid_o,
  output logic [7:0]            char_code_o,
  output logic                  last_o
);

  localparam int unsigned NUM_DIGITS = num_digits(VALUE_BITS);
  localparam int unsigned NUM_STAGES = (VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;

  logic [NUM_STAGES:0]     stg_valid;
  logic [NUM_STAGES:0]     stg_ready;
  logic [NUM_STAGES:0]     stg_neg;
  logic [VALUE_BITS-1:0]   stg_bin [NUM_STAGES+1];
  logic [4*NUM_DIGITS-1:0] stg_bcd [NUM_STAGES+1];

  logic                  front_valid_q;
  logic                  front_neg_q;
  logic [VALUE_BITS-1:0] front_mag_q;
  logic                  front_ready;

  assign front_ready = !front_valid_q || stg_ready[0];
  assign busy        = !front_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (front_ready) begin
      front_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_ready && start) begin
      front_neg_q <= value_i[VALUE_BITS-1];
      front_mag_q <= value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
    end
  end

  assign stg_valid[0] = front_valid_q;
  assign stg_neg[0]   = front_neg_q;
  assign stg_bin[0]   = front_mag_q;
  assign stg_bcd[0]   = '0;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_dabble
    localparam int unsigned Rest  = VALUE_BITS - i * DABBLE_STEPS;
    localparam int unsigned Steps = (Rest > DABBLE_STEPS) ? DABBLE_STEPS : Rest;

    s2da_dabble_stage #(
      .MAG_BITS  (VALUE_BITS),
      .NUM_DIGITS(NUM_DIGITS),
      .STEPS     (Steps)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stg_valid[i]),
      .in_ready_o (stg_ready[i]),
      .in_neg_i   (stg_neg[i]),
      .in_bin_i   (stg_bin[i]),
      .in_bcd_i   (stg_bcd[i]),
      .out_valid_o(stg_valid[i+1]),
      .out_ready_i(stg_ready[i+1]),
      .out_neg_o  (stg_neg[i+1]),
      .out_bin_o  (stg_bin[i+1]),
      .out_bcd_o  (stg_bcd[i+1])
    );
  end

  s2da_serializer #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[NUM_STAGES]),
    .in_ready_o  (stg_ready[NUM_STAGES]),
    .in_neg_i    (stg_neg[NUM_STAGES]),
    .in_bcd_i    (stg_bcd[NUM_STAGES]),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule
